/* hw/rtl/lfaq_pkg.sv */
// lfaq_pkg: shared widths, request kind codes and control structs for the
// linear function argmax query block; no dependencies
package lfaq_pkg;

	localparam int MAX_LINES_DEF = 1024;

	localparam int KIND_W = 2;
	localparam int BASE_W = 31;
	localparam int RATE_W = 31;
	localparam int DAY_W  = 31;
	localparam int IDX_W  = 11;
	localparam int VAL_W  = 62;
	localparam int LINE_W = BASE_W + RATE_W;

	localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
	localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

	typedef struct packed {
		logic start;
		logic valid;
	} eval_ctl_t;

endpackage

/* hw/rtl/lfaq_if.sv */
// lfaq_if: valid/ready channel interfaces for requests and results
// depends on lfaq_pkg
interface lfaq_req_if;
	logic                        valid;
	logic                        ready;
	logic [lfaq_pkg::KIND_W-1:0] kind;
	logic [lfaq_pkg::BASE_W-1:0] base;
	logic [lfaq_pkg::RATE_W-1:0] rate;
	logic [lfaq_pkg::DAY_W-1:0]  day;

	modport source (output valid, kind, base, rate, day, input ready);
	modport sink (input valid, kind, base, rate, day, output ready);
endinterface

interface lfaq_res_if;
	logic                       valid;
	logic                       ready;
	logic [lfaq_pkg::IDX_W-1:0] best_index;
	logic [lfaq_pkg::VAL_W-1:0] best_value;
	logic                       found;

	modport source (output valid, best_index, best_value, found, input ready);
	modport sink (input valid, best_index, best_value, found, output ready);
endinterface

/* hw/rtl/lfaq_ram.sv */
// lfaq_ram: generic single write port ram with registered read
// no dependencies
module lfaq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/lfaq_eval.sv */
// lfaq_eval: shared multiply, add and compare unit that keeps the running best line
// depends on lfaq_pkg
module lfaq_eval #(
	parameter int CW = 11
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lfaq_pkg::eval_ctl_t           ctl,
	input  logic [lfaq_pkg::BASE_W-1:0]   base,
	input  logic [lfaq_pkg::RATE_W-1:0]   rate,
	input  logic [lfaq_pkg::DAY_W-1:0]    day,
	input  logic [CW-1:0]                 idx,
	output logic [lfaq_pkg::VAL_W-1:0]    best_value,
	output logic [CW-1:0]                 best_idx,
	output logic                          busy
);

	logic                        v_s2;
	logic [lfaq_pkg::VAL_W-1:0]  prod_s2;
	logic [lfaq_pkg::BASE_W-1:0] base_s2;
	logic [CW-1:0]               idx_s2;

	logic                        v_s3;
	logic [lfaq_pkg::VAL_W-1:0]  sum_s3;
	logic [CW-1:0]               idx_s3;

	logic                        have_q;
	logic [lfaq_pkg::VAL_W-1:0]  best_val_q;
	logic [CW-1:0]               best_idx_q;
	logic                        take;

	// multiply stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= lfaq_pkg::VAL_W'(rate) * lfaq_pkg::VAL_W'(day);
		base_s2 <= base;
		idx_s2  <= idx;
	end

	// add stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		sum_s3 <= prod_s2 + lfaq_pkg::VAL_W'(base_s2);
		idx_s3 <= idx_s2;
	end

	// strictly greater keeps the lowest index on ties
	assign take = v_s3 && (!have_q || (sum_s3 > best_val_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (ctl.start) begin
			have_q <= 1'b0;
		end else if (v_s3) begin
			have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_val_q <= sum_s3;
			best_idx_q <= idx_s3;
		end
	end

	assign best_value = best_val_q;
	assign best_idx   = best_idx_q;
	assign busy       = v_s2 | v_s3;

endmodule

/* hw/rtl/linear_function_argmax_query.sv */
// linear_function_argmax_query: line table with argmax query over base + rate*day
// depends on lfaq_pkg, lfaq_if, lfaq_ram, lfaq_eval
//
// channel  dir  handshake    payload
// req      in   valid/ready  kind, base, rate, day
// res      out  valid/ready  best_index, best_value, found
//
// append, clear and ignored kinds are handled in the idle state, which stays ready
// a query: one ram read and one multiply-add per line, then a pipeline drain
// a query on an empty table skips the scan and goes straight to the done state
// reset clears the line count, sequencer and result valid flag; ram contents stay
// a finished query waits for the result register to empty before the next request
module linear_function_argmax_query #(
	parameter int MAX_LINES = lfaq_pkg::MAX_LINES_DEF
) (
	input logic           clk,
	input logic           arst_n,
	lfaq_req_if.sink      req,
	lfaq_res_if.source    res
);

	localparam int CW = $clog2(MAX_LINES + 1);
	localparam int AW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t                       state_q;
	logic [CW-1:0]                line_count_q;
	logic [AW-1:0]                rd_addr_q;
	logic [lfaq_pkg::DAY_W-1:0]   day_q;
	logic                         found_q;
	logic                         rd_v_s1;
	logic [CW-1:0]                idx_s1;

	logic                         res_valid_q;
	logic [lfaq_pkg::IDX_W-1:0]   res_index_q;
	logic [lfaq_pkg::VAL_W-1:0]   res_value_q;
	logic                         res_found_q;

	logic                         accept;
	logic                         ram_we;
	logic                         ram_re;
	logic [lfaq_pkg::LINE_W-1:0]  ram_rdata;
	logic                         last_rd;
	logic                         res_free;
	lfaq_pkg::eval_ctl_t          ev_ctl;
	logic [lfaq_pkg::VAL_W-1:0]   ev_value;
	logic [CW-1:0]                ev_idx;
	logic                         ev_busy;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign ram_we    = accept && (req.kind == lfaq_pkg::KIND_APPEND)
	                   && (line_count_q < CW'(MAX_LINES));
	assign ram_re    = (state_q == ST_SCAN);
	assign last_rd   = (CW'(rd_addr_q) == (line_count_q - CW'(1)));
	assign res_free  = !res_valid_q || res.ready;

	lfaq_ram #(
		.WIDTH (lfaq_pkg::LINE_W),
		.DEPTH (MAX_LINES)
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (line_count_q[AW-1:0]),
		.wdata ({req.base, req.rate}),
		.re    (ram_re),
		.raddr (rd_addr_q),
		.rdata (ram_rdata)
	);

	assign ev_ctl.start = accept && (req.kind == lfaq_pkg::KIND_QUERY);
	assign ev_ctl.valid = rd_v_s1;

	lfaq_eval #(
		.CW (CW)
	) u_eval (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ev_ctl),
		.base       (ram_rdata[lfaq_pkg::LINE_W-1:lfaq_pkg::RATE_W]),
		.rate       (ram_rdata[lfaq_pkg::RATE_W-1:0]),
		.day        (day_q),
		.idx        (idx_s1),
		.best_value (ev_value),
		.best_idx   (ev_idx),
		.busy       (ev_busy)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			line_count_q <= '0;
			rd_addr_q    <= '0;
			found_q      <= 1'b0;
			rd_v_s1      <= 1'b0;
		end else begin
			rd_v_s1 <= ram_re;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (req.kind)
							lfaq_pkg::KIND_APPEND: begin
								if (ram_we) begin
									line_count_q <= line_count_q + CW'(1);
								end
							end
							lfaq_pkg::KIND_QUERY: begin
								rd_addr_q <= '0;
								found_q   <= (line_count_q != '0);
								state_q   <= (line_count_q != '0) ? ST_SCAN : ST_DONE;
							end
							lfaq_pkg::KIND_CLEAR: begin
								line_count_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (last_rd) begin
						state_q <= ST_DRAIN;
					end else begin
						rd_addr_q <= rd_addr_q + AW'(1);
					end
				end
				ST_DRAIN: begin
					if (!rd_v_s1 && !ev_busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= CW'(rd_addr_q) + CW'(1);
		if (accept && (req.kind == lfaq_pkg::KIND_QUERY)) begin
			day_q <= req.day;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && res_free) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && res_free) begin
			res_index_q <= found_q ? lfaq_pkg::IDX_W'(ev_idx) : '0;
			res_value_q <= found_q ? ev_value : '0;
			res_found_q <= found_q;
		end
	end

	assign res.valid      = res_valid_q;
	assign res.best_index = res_index_q;
	assign res.best_value = res_value_q;
	assign res.found      = res_found_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		line_count_q <= CW'(MAX_LINES))
		else $error("line count beyond table depth");

	a_scan_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (CW'(rd_addr_q) < line_count_q))
		else $error("scan read beyond stored lines");

	a_best_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && found_q) |->
		(ev_idx != '0 && ev_idx <= line_count_q))
		else $error("best index outside stored lines");

	a_no_read_on_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |=> !ev_busy || $past(ev_busy) || $past(rd_v_s1))
		else $error("evaluation started without a scan");

endmodule
